// ===== hdl/ryb_to_rgb_color_convert_core_macros.svh =====
// assertion macros for the ryb to rgb colour converter
// expects clk_i and rst_ni in the scope that uses them
`ifndef RYB_TO_RGB_COLOR_CONVERT_CORE_MACROS_SVH
`define RYB_TO_RGB_COLOR_CONVERT_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define RGBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgbc check failed");

// next-cycle implication, checked out of reset
`define RGBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgbc check failed");

`endif

// ===== hdl/rgbc_pkg.sv =====
// shared constants and the colour cube corner table for the ryb to rgb converter
// no dependencies
package rgbc_pkg;

  localparam int FRAC_BITS_DEF = 15;
  localparam int FIELD_W       = 16;
  localparam int CHANNELS      = 3;
  localparam int CORNERS       = 8;
  localparam int TDATA_W       = CHANNELS * FIELD_W;

  // corner values in thousandths, [corner][channel]
  localparam int CORNER_MILLI [CORNERS][CHANNELS] = '{
    '{1000, 1000, 1000},
    '{1000, 1000,    0},
    '{1000,    0,    0},
    '{1000,  500,    0},
    '{ 163,  373,  600},
    '{   0,  660,  200},
    '{ 500,    0,  500},
    '{ 200,   94,    0}
  };

  // corner in fixed point, rounded to nearest
  function automatic longint corner_fx(input int k, input int ch, input int frac);
    longint one;
    one = longint'(1) << frac;
    return (longint'(CORNER_MILLI[k][ch]) * one + 64'sd500) / 1000;
  endfunction

endpackage

// ===== hdl/rgbc_weight.sv =====
// smoothstep weight w = t*t*(3-2t) over three register stages
// depends on rgbc_pkg
module rgbc_weight #(
  parameter int FRAC_BITS = rgbc_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [rgbc_pkg::FIELD_W-1:0] t_i,
  output logic [FRAC_BITS:0]         w_o
);

  localparam int VW = FRAC_BITS + 1;
  localparam int EW = (VW > rgbc_pkg::FIELD_W) ? VW : rgbc_pkg::FIELD_W;
  localparam logic [VW-1:0] ONE       = VW'(1) << FRAC_BITS;
  localparam logic [VW-1:0] HALF      = VW'(1) << (FRAC_BITS - 1);
  localparam logic [VW:0]   THREE_ONE = (VW + 1)'(3) << FRAC_BITS;

  logic [EW-1:0]     t_ext;
  logic [VW-1:0]     t_sat;
  logic [VW-1:0]     t_q;
  logic [2*VW-1:0]   sq_q;
  logic [2*VW-1:0]   sq_rnd;
  logic [VW-1:0]     t2;
  logic [VW:0]       poly;
  logic [2*VW:0]     p_q;
  logic [2*VW:0]     p_rnd;
  logic [VW-1:0]     w_d;
  logic [VW-1:0]     w_q;

  // stage 1: saturate to one and square
  assign t_ext = EW'(t_i);
  assign t_sat = (t_ext > EW'(ONE)) ? ONE : t_ext[VW-1:0];

  // stage 2: round the square, multiply by 3 - 2t
  assign sq_rnd = (sq_q + (2*VW)'(HALF)) >> FRAC_BITS;
  assign t2     = sq_rnd[VW-1:0];
  assign poly   = THREE_ONE - {t_q, 1'b0};

  // stage 3: round and limit to one
  assign p_rnd = (p_q + (2*VW+1)'(HALF)) >> FRAC_BITS;
  assign w_d   = (p_rnd > (2*VW+1)'(ONE)) ? ONE : p_rnd[VW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q  <= t_sat;
      sq_q <= (2*VW)'(t_sat) * (2*VW)'(t_sat);
      p_q  <= (2*VW+1)'(t2) * (2*VW+1)'(poly);
      w_q  <= w_d;
    end
  end

  assign w_o = w_q;

endmodule

// ===== hdl/rgbc_lerp.sv =====
// one interpolation a + sign(b-a) * round(w*|b-a|), product and add in two stages
// depends on rgbc_pkg
module rgbc_lerp #(
  parameter int FRAC_BITS = rgbc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [FRAC_BITS:0] w_i,
  input  logic [FRAC_BITS:0] a_i,
  input  logic [FRAC_BITS:0] b_i,
  output logic [FRAC_BITS:0] y_o
);

  localparam int VW = FRAC_BITS + 1;
  localparam logic [VW-1:0] HALF = VW'(1) << (FRAC_BITS - 1);

  logic              neg;
  logic [VW-1:0]     diff;
  logic [2*VW-1:0]   prod_q;
  logic [VW-1:0]     a_q;
  logic              neg_q;
  logic [2*VW-1:0]   prod_rnd;
  logic [VW-1:0]     step;
  logic [VW-1:0]     y_d;
  logic [VW-1:0]     y_q;

  assign neg  = (b_i < a_i);
  assign diff = neg ? (a_i - b_i) : (b_i - a_i);

  // rounding half away from zero, step never exceeds |b-a|
  assign prod_rnd = (prod_q + (2*VW)'(HALF)) >> FRAC_BITS;
  assign step     = prod_rnd[VW-1:0];
  assign y_d      = neg_q ? (a_q - step) : (a_q + step);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= (2*VW)'(w_i) * (2*VW)'(diff);
      a_q    <= a_i;
      neg_q  <= neg;
      y_q    <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

// ===== hdl/ryb_to_rgb_color_convert_core.sv =====
// ryb to rgb colour converter, smoothstep-weighted trilinear cube interpolation
// input transfer to output valid passes the weight stages, then the blue, yellow and red axis stages
// throughput: one pixel per cycle; the nine stages share one advance enable
// that stalls only while the output register holds an untaken result
// reset clears the stage valid bits only; payload registers are not reset
// depends on rgbc_pkg, rgbc_weight, rgbc_lerp and the assertion macro header
`include "ryb_to_rgb_color_convert_core_macros.svh"

module ryb_to_rgb_color_convert_core #(
  parameter int FRAC_BITS = rgbc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // red_in [15:0], yellow_in [31:16], blue_in [47:32]
  input  logic [rgbc_pkg::TDATA_W-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // red_out [15:0], green_out [31:16], blue_out [47:32]
  output logic [rgbc_pkg::TDATA_W-1:0] m_axis_tdata
);

  localparam int VW     = FRAC_BITS + 1;
  localparam int FW     = rgbc_pkg::FIELD_W;
  localparam int NCH    = rgbc_pkg::CHANNELS;
  localparam int STAGES = 9;
  localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

  logic              en;
  logic [STAGES-1:0] vld_q;
  logic              out_in_range;

  logic [VW-1:0] w_r, w_y, w_b;
  logic [VW-1:0] wy_q [2];
  logic [VW-1:0] wr_q [4];

  logic [VW-1:0] x_v [NCH][4];
  logic [VW-1:0] y_v [NCH][2];
  logic [VW-1:0] v_v [NCH];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[STAGES-2:0], s_axis_tvalid};
    end
  end

  rgbc_weight #(.FRAC_BITS(FRAC_BITS)) u_weight_r (
    .clk_i (clk_i), .en_i (en), .t_i (s_axis_tdata[FW-1:0]), .w_o (w_r)
  );
  rgbc_weight #(.FRAC_BITS(FRAC_BITS)) u_weight_y (
    .clk_i (clk_i), .en_i (en), .t_i (s_axis_tdata[2*FW-1:FW]), .w_o (w_y)
  );
  rgbc_weight #(.FRAC_BITS(FRAC_BITS)) u_weight_b (
    .clk_i (clk_i), .en_i (en), .t_i (s_axis_tdata[3*FW-1:2*FW]), .w_o (w_b)
  );

  // line up the yellow and red weights with their interpolation stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      wy_q[0] <= w_y;
      wy_q[1] <= wy_q[0];
      wr_q[0] <= w_r;
      wr_q[1] <= wr_q[0];
      wr_q[2] <= wr_q[1];
      wr_q[3] <= wr_q[2];
    end
  end

  for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
    // blue axis between fixed corners
    for (genvar k = 0; k < 4; k++) begin : g_blue
      localparam logic [VW-1:0] CA = VW'(rgbc_pkg::corner_fx(k, ch, FRAC_BITS));
      localparam logic [VW-1:0] CB = VW'(rgbc_pkg::corner_fx(k + 4, ch, FRAC_BITS));
      rgbc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
        .clk_i (clk_i), .en_i (en), .w_i (w_b), .a_i (CA), .b_i (CB),
        .y_o   (x_v[ch][k])
      );
    end

    // yellow axis
    for (genvar j = 0; j < 2; j++) begin : g_yellow
      rgbc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
        .clk_i (clk_i), .en_i (en), .w_i (wy_q[1]),
        .a_i   (x_v[ch][2*j]), .b_i (x_v[ch][2*j+1]), .y_o (y_v[ch][j])
      );
    end

    // red axis, its add stage is the output register
    rgbc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_red (
      .clk_i (clk_i), .en_i (en), .w_i (wr_q[3]),
      .a_i   (y_v[ch][0]), .b_i (y_v[ch][1]), .y_o (v_v[ch])
    );

    assign m_axis_tdata[ch*FW +: FW] = FW'(v_v[ch]);
  end

  assign out_in_range = (m_axis_tdata[15:0] <= ONE) && (m_axis_tdata[31:16] <= ONE) &&
                        (m_axis_tdata[47:32] <= ONE);

  `RGBC_ASSERT_IMP(a_out_range, m_axis_tvalid, out_in_range)
  `RGBC_ASSERT_IMP(a_weight_range, 1'b1, (w_r <= ONE) && (w_y <= ONE) && (w_b <= ONE))
  `RGBC_ASSERT_NXT(a_no_phantom_entry, s_axis_tready && !s_axis_tvalid, !vld_q[0])

endmodule

// ===== sim/tb.sv =====
// testbench for ryb_to_rgb_color_convert_core: drives ryb pixels, predicts rgb in fixed point
// depends on rgbc_pkg and the converter rtl; nothing else is read
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CLK_PERIOD   = 10;
  localparam int     FB           = 15;
  localparam longint ONE          = 64'sd1 <<< FB;
  localparam longint HALF         = 64'sd1 <<< (FB - 1);
  localparam int     RANDOM_TOTAL = 1550;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     DRAIN_CYCLES = 30;
  // watchdog limit, many times over the slowest legal run
  localparam int     CYCLE_LIMIT  = 400000;

  // cube corners in thousandths, [corner][r, g, b]
  localparam int CUBE_MILLI [8][3] = '{
    '{1000, 1000, 1000},
    '{1000, 1000,    0},
    '{1000,    0,    0},
    '{1000,  500,    0},
    '{ 163,  373,  600},
    '{   0,  660,  200},
    '{ 500,    0,  500},
    '{ 200,   94,    0}
  };

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] yellow;
    logic [15:0] red;
  } ryb_t;

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } rgb_t;

  class rgb_tracker;
    rgb_t expected_rgb[$];
    int   errors;
    int   accepted;
    int   compared;

    function new();
      errors   = 0;
      accepted = 0;
      compared = 0;
    endfunction

    function longint corner_q(int k, int ch);
      return (longint'(CUBE_MILLI[k][ch]) * ONE + 500) / 1000;
    endfunction

    // smoothstep t*t*(3-2t) in fixed point
    function longint smooth(longint t);
      longint sq;
      longint w;
      sq = (t * t + HALF) >>> FB;
      w  = (sq * (3 * ONE - 2 * t) + HALF) >>> FB;
      if (w > ONE) w = ONE;
      if (w < 0) w = 0;
      return w;
    endfunction

    // rounds half away from zero, so the result stays between a and b
    function longint blend(longint w, longint a, longint b);
      if (b >= a) return a + ((w * (b - a) + HALF) >>> FB);
      return a - ((w * (a - b) + HALF) >>> FB);
    endfunction

    function longint clip_in(logic [15:0] v);
      if (longint'(v) > ONE) return ONE;
      return longint'(v);
    endfunction

    function logic [15:0] channel(int ch, longint wr, longint wy, longint wb);
      longint x [4];
      longint y0;
      longint y1;
      longint v;
      for (int k = 0; k < 4; k++) x[k] = blend(wb, corner_q(k, ch), corner_q(k + 4, ch));
      y0 = blend(wy, x[0], x[1]);
      y1 = blend(wy, x[2], x[3]);
      v  = blend(wr, y0, y1);
      if (v < 0) v = 0;
      if (v > ONE) v = ONE;
      return v[15:0];
    endfunction

    function rgb_t ryb_to_rgb(ryb_t p);
      rgb_t   q;
      longint wr;
      longint wy;
      longint wb;
      wr      = smooth(clip_in(p.red));
      wy      = smooth(clip_in(p.yellow));
      wb      = smooth(clip_in(p.blue));
      q.red   = channel(0, wr, wy, wb);
      q.green = channel(1, wr, wy, wb);
      q.blue  = channel(2, wr, wy, wb);
      return q;
    endfunction

    function void note_pixel(ryb_t p);
      expected_rgb.push_back(ryb_to_rgb(p));
      accepted++;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_pixel(rgb_t got);
      rgb_t want;
      if (expected_rgb.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got r=%0d g=%0d b=%0d",
                 $time, got.red, got.green, got.blue);
        return;
      end
      want = expected_rgb.pop_front();
      compared++;
      compare_field("red_out", want.red, got.red);
      compare_field("green_out", want.green, got.green);
      compare_field("blue_out", want.blue, got.blue);
    endfunction

    function int pending();
      return expected_rgb.size();
    endfunction

    function void flush_leftover();
      rgb_t want;
      while (expected_rgb.size() != 0) begin
        want = expected_rgb.pop_front();
        errors++;
        $display("%0t: missing result, expected r=%0d g=%0d b=%0d, got none",
                 $time, want.red, want.green, want.blue);
      end
    endfunction
  endclass

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic [rgbc_pkg::TDATA_W-1:0] s_axis_tdata  = '0;
  logic                         m_axis_tready = 1'b0;
  logic                         s_axis_tready;
  logic                         m_axis_tvalid;
  logic [rgbc_pkg::TDATA_W-1:0] m_axis_tdata;

  rgb_tracker track = new();

  int  send_gap_pct = 10;
  int  recv_gap_pct = 59;
  bit  rx_hold      = 1'b0;
  int  cycles       = 0;
  event hold_go;

  ryb_to_rgb_color_convert_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // long output stall, counted here while the sender keeps offering
  initial begin
    forever begin
      @(hold_go);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) track.note_pixel(s_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) track.check_pixel(m_axis_tdata);
  end

  function automatic ryb_t mk(int r, int y, int b);
    ryb_t p;
    p.red    = r[15:0];
    p.yellow = y[15:0];
    p.blue   = b[15:0];
    return p;
  endfunction

  // mostly in range, with the ends and saturating values mixed in
  function automatic logic [15:0] rand_component();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic ryb_t rand_pixel();
    ryb_t p;
    p.red    = rand_component();
    p.yellow = rand_component();
    p.blue   = rand_component();
    return p;
  endfunction

  // ends on the rising edge at which the pixel transfer happens
  task automatic send_pixel(ryb_t p);
    bit took;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {16'($urandom), 32'($urandom)};
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // cube corners, saturation and a few interior points
    send_pixel(mk(0, 0, 0));
    send_pixel(mk(32768, 0, 0));
    send_pixel(mk(0, 32768, 0));
    send_pixel(mk(0, 0, 32768));
    send_pixel(mk(32768, 32768, 0));
    send_pixel(mk(32768, 0, 32768));
    send_pixel(mk(0, 32768, 32768));
    send_pixel(mk(32768, 32768, 32768));
    send_pixel(mk(32769, 32769, 32769));
    send_pixel(mk(65535, 65535, 65535));
    send_pixel(mk(65535, 0, 40000));
    send_pixel(mk(1, 1, 1));
    send_pixel(mk(16384, 16384, 16384));
    send_pixel(mk(32767, 32767, 32767));
    send_pixel(mk(8192, 24576, 16384));
    send_pixel(mk(16'h5555, 16'h2aaa, 16'h1555));
    send_pixel(mk(16'haaaa, 16'h8000, 16'h7fff));
    send_pixel(mk(12345, 30000, 5000));
    send_pixel(mk(32768, 16384, 1));

    for (int i = 0; i < RANDOM_TOTAL / 3; i++) begin
      if (i == 100) -> hold_go;
      send_pixel(rand_pixel());
    end

    send_gap_pct = 59;
    recv_gap_pct <= 10;
    for (int i = 0; i < RANDOM_TOTAL / 3; i++) send_pixel(rand_pixel());

    send_gap_pct = 0;
    recv_gap_pct <= 0;
    -> hold_go;
    for (int i = 0; i < RANDOM_TOTAL - 2 * (RANDOM_TOTAL / 3); i++) send_pixel(rand_pixel());
    s_axis_tvalid <= 1'b0;

    while (track.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    track.flush_leftover();

    $display("tb: %0d pixels in, %0d rgb results compared, %0d errors",
             track.accepted, track.compared, track.errors);
    $display("tb: corners and saturating inputs, then three idle mixes and two long stalls");
    if (track.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
